### hdl/pvd_pkg.sv
`timescale 1ns / 1ps

package pvd_pkg;

    // One byte of the encoded stream as it arrives on the input channel.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } t_pvd_in;

    // One decoded result as it leaves on the output channel.
    typedef struct packed {
        logic [63:0] value;
        logic [3:0]  code_length;
        logic [1:0]  status;
    } t_pvd_out;

    // A finished or truncated code handed from the framing stage to the finishing stage.
    // The payload still lacks the length offset.
    typedef struct packed {
        logic        truncated;
        logic [63:0] payload;
        logic [3:0]  length;
    } t_pvd_code;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TRUNC    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [3:0] LEN_ONE = 4'd1;
    localparam logic [3:0] LEN_MAX = 4'd9;

    // Code length from the first byte: one more than its leading ones.
    function automatic logic [3:0] code_len_of(input logic [7:0] b);
        logic [3:0] n;
        logic       run;
        begin
            n   = LEN_ONE;
            run = 1'b1;
            for (int k = 7; k >= 0; k--) begin
                if (run && b[k]) begin
                    n = n + 4'd1;
                end else begin
                    run = 1'b0;
                end
            end
            return n;
        end
    endfunction

    // Payload bits that the first byte carries below its length prefix.
    function automatic logic [7:0] first_mask(input logic [3:0] n);
        logic [7:0] m;
        begin
            case (n)
                4'd0:    m = 8'h7F;
                4'd1:    m = 8'h7F;
                4'd2:    m = 8'h3F;
                4'd3:    m = 8'h1F;
                4'd4:    m = 8'h0F;
                4'd5:    m = 8'h07;
                4'd6:    m = 8'h03;
                4'd7:    m = 8'h01;
                default: m = 8'h00;
            endcase
            return m;
        end
    endfunction

    // Offset added per length so that every value has exactly one encoding.
    function automatic logic [63:0] len_offset(input logic [3:0] n);
        logic [63:0] off;
        begin
            case (n)
                4'd2:    off = 64'h0000_0000_0000_0080;
                4'd3:    off = 64'h0000_0000_0000_4080;
                4'd4:    off = 64'h0000_0000_0020_4080;
                4'd5:    off = 64'h0000_0000_1020_4080;
                4'd6:    off = 64'h0000_0008_1020_4080;
                4'd7:    off = 64'h0000_0408_1020_4080;
                4'd8:    off = 64'h0002_0408_1020_4080;
                4'd9:    off = 64'h0102_0408_1020_4080;
                default: off = 64'h0;
            endcase
            return off;
        end
    endfunction

endpackage

### hdl/pvd_frame.sv
`timescale 1ns / 1ps

module pvd_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  pvd_pkg::t_pvd_in    i_item,
    output logic                o_stall,
    input  logic                i_drain,
    output logic                o_code_valid,
    output pvd_pkg::t_pvd_code  o_code
);
    import pvd_pkg::*;

    logic [3:0]  r_rem;
    logic [3:0]  n_rem;
    logic [63:0] r_acc;
    logic [63:0] n_acc;
    logic [3:0]  r_len;
    logic [3:0]  n_len;
    logic        r_code_valid;
    logic        n_code_valid;
    t_pvd_code   r_code;

    logic        accept;
    logic        emit;
    t_pvd_code   code;
    logic [3:0]  first_len;
    logic [3:0]  rem_dec;
    logic [63:0] acc_shift;

    assign o_stall   = r_code_valid && !i_drain;
    assign accept    = i_valid && !o_stall;
    assign first_len = code_len_of(i_item.data_byte);
    assign rem_dec   = r_rem - 4'd1;
    assign acc_shift = {r_acc[55:0], i_item.data_byte};

    always_comb begin
        n_rem = r_rem;
        n_acc = r_acc;
        n_len = r_len;
        emit  = 1'b0;
        code  = '0;
        if (accept) begin
            if (r_rem == 4'd0 || r_rem > 4'd8) begin
                if (first_len == LEN_ONE) begin
                    emit         = 1'b1;
                    code.payload = {56'd0, i_item.data_byte};
                    code.length  = LEN_ONE;
                end else if (i_item.buffer_end) begin
                    emit           = 1'b1;
                    code.truncated = 1'b1;
                    code.length    = LEN_ONE;
                    n_rem          = 4'd0;
                    n_acc          = '0;
                    n_len          = 4'd0;
                end else begin
                    n_acc = {56'd0, i_item.data_byte & first_mask(first_len)};
                    n_len = first_len;
                    n_rem = first_len - 4'd1;
                end
            end else begin
                if (rem_dec == 4'd0) begin
                    // The byte that completes the code.
                    emit         = 1'b1;
                    code.payload = acc_shift;
                    code.length  = (r_len > LEN_MAX) ? LEN_MAX : r_len;
                    n_rem        = 4'd0;
                    n_acc        = '0;
                    n_len        = 4'd0;
                end else if (i_item.buffer_end) begin
                    emit           = 1'b1;
                    code.truncated = 1'b1;
                    code.length    = r_len - rem_dec;
                    n_rem          = 4'd0;
                    n_acc          = '0;
                    n_len          = 4'd0;
                end else begin
                    n_acc = acc_shift;
                    n_rem = rem_dec;
                end
            end
        end
    end

    assign n_code_valid = emit || (r_code_valid && !i_drain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem        <= 4'd0;
            r_acc        <= '0;
            r_len        <= 4'd0;
            r_code_valid <= 1'b0;
        end else begin
            r_rem        <= n_rem;
            r_acc        <= n_acc;
            r_len        <= n_len;
            r_code_valid <= n_code_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_code <= code;
        end
    end

    assign o_code_valid = r_code_valid;
    assign o_code       = r_code;

endmodule

### hdl/pvd_finish.sv
`timescale 1ns / 1ps

module pvd_finish (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_check_overflow,
    input  logic                i_code_valid,
    input  pvd_pkg::t_pvd_code  i_code,
    output logic                o_ready,
    output logic                o_valid,
    output pvd_pkg::t_pvd_out   o_result,
    input  logic                i_stall
);
    import pvd_pkg::*;

    logic        r_valid;
    logic        n_valid;
    t_pvd_out    r_result;
    t_pvd_out    result;
    logic        load;
    logic [64:0] sum;

    assign o_ready = !r_valid || !i_stall;
    assign load    = i_code_valid && o_ready;
    assign sum     = {1'b0, i_code.payload} + {1'b0, len_offset(i_code.length)};

    always_comb begin
        result.code_length = i_code.length;
        if (i_code.truncated) begin
            result.value  = '0;
            result.status = STATUS_TRUNC;
        end else if (i_code.length == LEN_MAX && sum[64] && i_check_overflow) begin
            result.value  = '0;
            result.status = STATUS_OVERFLOW;
        end else begin
            result.value  = sum[63:0];
            result.status = STATUS_OK;
        end
    end

    assign n_valid = load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### hdl/prefix_varint_decoder.sv
`timescale 1ns / 1ps

// Prefix varint decoder for 64-bit naturals. Bytes of the encoded stream
// arrive one per transfer on the input channel; the count of leading ones in
// a code's first byte sets its length from 1 to 9 bytes, the payload bits are
// read big-endian, and a per-length offset is added so each value has one
// encoding. One result transfer leaves for each completed code, and one for a
// code that a byte marked buffer_end cuts short (value 0, status truncated,
// code_length the bytes taken so far). With check_overflow set, a 9-byte code
// whose sum wraps past 2^64 gives value 0 and status overflow; cleared, it
// gives the wrapped sum. The block takes one byte every cycle unless the
// input is stalled. The byte that ends a code is framed into the code
// register at its own transfer edge; the finishing stage then adds the
// length offset, checks for overflow and registers the result that is
// presented on the output. Both stages are registered, so a stalled output
// does not stop the input until a second finished code is waiting behind
// it. The configuration register may only be written while the block is
// idle; its write port is always ready.

module prefix_varint_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input byte channel.
    input  logic               i_in_valid,
    input  pvd_pkg::t_pvd_in   i_in_data,
    output logic               o_in_stall,
    // Result channel.
    output logic               o_out_valid,
    output pvd_pkg::t_pvd_out  o_out_data,
    input  logic               i_out_stall,
    // Configuration write channel: bit 0 is check_overflow.
    input  logic               i_cfg_valid,
    input  logic               i_cfg_data,
    output logic               o_cfg_ready
);
    import pvd_pkg::*;

    logic      r_check_overflow;
    logic      code_valid;
    t_pvd_code code;
    logic      finish_ready;

    // The configuration register reset value enables overflow checking.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_overflow <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_check_overflow <= i_cfg_data;
        end
    end

    // Framing stage: tracks the code in progress and registers each finished
    // or truncated code.
    pvd_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_item       (i_in_data),
        .o_stall      (o_in_stall),
        .i_drain      (finish_ready),
        .o_code_valid (code_valid),
        .o_code       (code)
    );

    // Finishing stage: adds the length offset, checks for wrap, and holds the
    // result until the output transfer completes.
    pvd_finish u_finish (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_check_overflow (r_check_overflow),
        .i_code_valid     (code_valid),
        .i_code           (code),
        .o_ready          (finish_ready),
        .o_valid          (o_out_valid),
        .o_result         (o_out_data),
        .i_stall          (i_out_stall)
    );

endmodule
